FILE: rtl/gaussian_blur_3x3_rgb_assert.svh
// Assertion macros for the blur RTL, included by gb3_blur_out.sv.
`ifndef GAUSSIAN_BLUR_3X3_RGB_ASSERT_SVH
`define GAUSSIAN_BLUR_3X3_RGB_ASSERT_SVH
`ifndef SYNTHESIS
`define GB3_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gb3 assertion failed");
`define GB3_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gb3 assertion failed");
`else
`define GB3_ASSERT_IMP(lbl, ante, cons)
`define GB3_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/gb3_pkg.sv
// Shared types, constants and kernel arithmetic for the 3x3 RGB blur.
package gb3_pkg;

   localparam int MAX_COLS_DEF = 1024;
   localparam int MAX_ROWS_DEF = 1024;
   localparam int CHAN_W       = 8;
   localparam int PIX_W        = 3 * CHAN_W;
   localparam int SIZE_W       = 11;
   localparam int POS_W        = 10;
   localparam int SUM_W        = CHAN_W + 4;

   localparam int CH_BLUE  = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_RED   = 2;

   typedef logic [PIX_W-1:0] pix_type;
   typedef logic [8:0][PIX_W-1:0] win_type;
   typedef logic [2:0][1:0] sel_type;

   typedef enum logic [0:0] {
      CSR_IMAGE_ROWS = 1'b0,
      CSR_IMAGE_COLS = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic row_ge1;
      logic row_eq1;
      logic row_last;
      logic col_ge1;
      logic col_eq1;
      logic col_last;
   } flags_type;

   // Window taps for one axis; the border side repeats the nearest real pixel.
   function automatic sel_type border_sel(logic second, logic at_one, logic at_zero);
      sel_type s;
      s[2] = 2'd2;
      if (!second) begin
         s[1] = 2'd1;
         s[0] = at_one ? 2'd1 : 2'd0;
      end else begin
         s[1] = 2'd2;
         s[0] = at_zero ? 2'd2 : 2'd1;
      end
      return s;
   endfunction

   function automatic logic [CHAN_W-1:0] blur_chan(win_type w, sel_type rs, sel_type cs,
                                                    int ch);
      logic [SUM_W-1:0]  sum;
      logic [3:0]        k;
      pix_type           p;
      logic [CHAN_W-1:0] v;
      int                sh;
      sum = '0;
      for (int a = 0; a < 3; a++) begin
         for (int b = 0; b < 3; b++) begin
            k   = 4'(cs[b]) * 4'd3 + 4'(rs[a]);
            p   = w[k];
            v   = p[ch*CHAN_W +: CHAN_W];
            sh  = ((a == 1) ? 1 : 0) + ((b == 1) ? 1 : 0);
            sum = sum + (SUM_W'(v) << sh);
         end
      end
      return sum[SUM_W-1 -: CHAN_W];
   endfunction

endpackage

FILE: rtl/gaussian_blur_3x3_rgb.sv
// Top level of the streaming 3x3 Gaussian blur for RGB pixels.
// Pixels enter on the req_ channel in raster order, one beat per pixel, for an
// image whose size is set through the csr_ channel (index 0 rows, 1 columns).
// Each rsp_ beat carries one filtered pixel with its row and column; rsp_run_last
// marks the final beat caused by one input pixel.
// The pipeline is a line store stage with registered reads, a window stage and a
// result register, passed in that order. A pixel enters every cycle while each
// causes at most one result and the receiver is ready. A pixel in row 0 or column
// 0 causes none unless that row or column is also the last; other pixels cause
// one, two in the last row or column and four at the last pixel of the image,
// and while extra results remain the input is held. When the receiver stalls,
// stages with room keep taking pixels; once all three are full, req_ready follows
// rsp_ready in the same cycle if one result is left in the window stage, and is
// low otherwise. Reset empties the pipeline, sets the size to one by one and
// restarts at row 0, column 0; the line stores are not cleared. Configuration
// must be written only while the block is idle; the block does not enforce this.
module gaussian_blur_3x3_rgb #(
   parameter int MAX_COLS = gb3_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = gb3_pkg::MAX_ROWS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [gb3_pkg::CHAN_W-1:0]  req_red_in,
   input  logic [gb3_pkg::CHAN_W-1:0]  req_green_in,
   input  logic [gb3_pkg::CHAN_W-1:0]  req_blue_in,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [gb3_pkg::CHAN_W-1:0]  rsp_red_out,
   output logic [gb3_pkg::CHAN_W-1:0]  rsp_green_out,
   output logic [gb3_pkg::CHAN_W-1:0]  rsp_blue_out,
   output logic [gb3_pkg::POS_W-1:0]   rsp_out_row,
   output logic [gb3_pkg::POS_W-1:0]   rsp_out_col,
   output logic                        rsp_run_last,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [0:0]                  csr_index,
   input  logic [gb3_pkg::SIZE_W-1:0]  csr_data
);

   localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

   logic [RW-1:0]       row_last_ff, row_last_in;
   logic [CW-1:0]       col_last_ff, col_last_in;
   logic [RW-1:0]       row_ff, row_in;
   logic [CW-1:0]       col_ff, col_in;
   logic [RW-1:0]       row_eff;
   logic [CW-1:0]       col_eff;
   logic                accept;
   gb3_pkg::flags_type  flags;
   gb3_pkg::pix_type    pix;

   logic                s1_valid, s1_ready;
   gb3_pkg::pix_type    s1_pix, s1_top, s1_mid;
   logic [RW-1:0]       s1_row;
   logic [CW-1:0]       s1_col;
   gb3_pkg::flags_type  s1_flags;

   assign csr_ready = 1'b1;

   always_comb begin
      row_last_in = row_last_ff;
      col_last_in = col_last_ff;
      if (csr_valid) begin
         unique case (gb3_pkg::csr_index_type'(csr_index))
            gb3_pkg::CSR_IMAGE_ROWS: begin
               if (csr_data == '0) begin
                  row_last_in = '0;
               end else if (32'(csr_data) > MAX_ROWS) begin
                  row_last_in = RW'(MAX_ROWS - 1);
               end else begin
                  row_last_in = RW'(csr_data - 1'b1);
               end
            end
            gb3_pkg::CSR_IMAGE_COLS: begin
               if (csr_data == '0) begin
                  col_last_in = '0;
               end else if (32'(csr_data) > MAX_COLS) begin
                  col_last_in = CW'(MAX_COLS - 1);
               end else begin
                  col_last_in = CW'(csr_data - 1'b1);
               end
            end
            default: begin
               row_last_in = row_last_ff;
            end
         endcase
      end
   end

   assign accept  = req_valid && req_ready;
   assign row_eff = (row_ff > row_last_ff) ? row_last_ff : row_ff;
   assign col_eff = (col_ff > col_last_ff) ? col_last_ff : col_ff;
   assign pix     = {req_red_in, req_green_in, req_blue_in};

   assign flags.row_ge1  = row_eff != '0;
   assign flags.row_eq1  = row_eff == RW'(1);
   assign flags.row_last = row_eff == row_last_ff;
   assign flags.col_ge1  = col_eff != '0;
   assign flags.col_eq1  = col_eff == CW'(1);
   assign flags.col_last = col_eff == col_last_ff;

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (accept) begin
         if (flags.col_last) begin
            col_in = '0;
            row_in = flags.row_last ? '0 : row_eff + RW'(1);
         end else begin
            col_in = col_eff + CW'(1);
            row_in = row_eff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_last_ff <= '0;
         col_last_ff <= '0;
         row_ff      <= '0;
         col_ff      <= '0;
      end else begin
         row_last_ff <= row_last_in;
         col_last_ff <= col_last_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
      end
   end

   gb3_line_buf #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_line_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_pix    (pix),
      .in_row    (row_eff),
      .in_col    (col_eff),
      .in_flags  (flags),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_pix   (s1_pix),
      .out_top   (s1_top),
      .out_mid   (s1_mid),
      .out_row   (s1_row),
      .out_col   (s1_col),
      .out_flags (s1_flags)
   );

   gb3_blur_out #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_blur_out (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (s1_valid),
      .in_ready      (s1_ready),
      .in_pix        (s1_pix),
      .in_top        (s1_top),
      .in_mid        (s1_mid),
      .in_row        (s1_row),
      .in_col        (s1_col),
      .in_flags      (s1_flags),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_run_last  (rsp_run_last)
   );

endmodule

FILE: rtl/gb3_line_buf.sv
// Line store stage: two buffered image rows and the pixel that reads them.
module gb3_line_buf #(
   parameter int MAX_COLS = gb3_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = gb3_pkg::MAX_ROWS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  gb3_pkg::pix_type     in_pix,
   input  logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] in_row,
   input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] in_col,
   input  gb3_pkg::flags_type   in_flags,
   output logic                 out_valid,
   input  logic                 out_ready,
   output gb3_pkg::pix_type     out_pix,
   output gb3_pkg::pix_type     out_top,
   output gb3_pkg::pix_type     out_mid,
   output logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] out_row,
   output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] out_col,
   output gb3_pkg::flags_type   out_flags
);

   localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int LW = 2 * gb3_pkg::PIX_W;

   logic [LW-1:0]       mem [MAX_COLS];
   logic                valid_ff, valid_in;
   gb3_pkg::pix_type    pix_ff;
   logic [RW-1:0]       row_ff;
   logic [CW-1:0]       col_ff;
   gb3_pkg::flags_type  flags_ff;
   logic [LW-1:0]       rd_ff;
   logic                byp_ff;
   logic [LW-1:0]       byp_data_ff;
   logic [LW-1:0]       line;
   logic [LW-1:0]       wr_data;
   logic                accept;
   logic                move;

   assign in_ready = !valid_ff || out_ready;
   assign accept   = in_valid && in_ready;
   assign move     = valid_ff && out_ready;

   // A beat that reads the column the leaving beat writes takes the new data.
   assign line    = byp_ff ? byp_data_ff : rd_ff;
   assign out_top = line[LW-1 -: gb3_pkg::PIX_W];
   assign out_mid = line[gb3_pkg::PIX_W-1:0];
   assign wr_data = {out_mid, pix_ff};

   assign out_valid = valid_ff;
   assign out_pix   = pix_ff;
   assign out_row   = row_ff;
   assign out_col   = col_ff;
   assign out_flags = flags_ff;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (move) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         mem[col_ff] <= wr_data;
      end
      if (accept) begin
         rd_ff       <= mem[in_col];
         byp_ff      <= valid_ff && (col_ff == in_col);
         byp_data_ff <= wr_data;
         pix_ff      <= in_pix;
         row_ff      <= in_row;
         col_ff      <= in_col;
         flags_ff    <= in_flags;
      end
   end

endmodule

FILE: rtl/gb3_blur_out.sv
// Window stage, kernel sums and the result register.
`include "gaussian_blur_3x3_rgb_assert.svh"
module gb3_blur_out #(
   parameter int MAX_COLS = gb3_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = gb3_pkg::MAX_ROWS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  gb3_pkg::pix_type            in_pix,
   input  gb3_pkg::pix_type            in_top,
   input  gb3_pkg::pix_type            in_mid,
   input  logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] in_row,
   input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] in_col,
   input  gb3_pkg::flags_type          in_flags,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [gb3_pkg::CHAN_W-1:0]  rsp_red_out,
   output logic [gb3_pkg::CHAN_W-1:0]  rsp_green_out,
   output logic [gb3_pkg::CHAN_W-1:0]  rsp_blue_out,
   output logic [gb3_pkg::POS_W-1:0]   rsp_out_row,
   output logic [gb3_pkg::POS_W-1:0]   rsp_out_col,
   output logic                        rsp_run_last
);

   localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

   gb3_pkg::win_type    win_ff, win_in;
   logic [3:0]          mask_ff, mask_in;
   gb3_pkg::flags_type  flags_ff;
   logic [RW-1:0]       row_ff;
   logic [CW-1:0]       col_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [gb3_pkg::CHAN_W-1:0] red_ff, green_ff, blue_ff;
   logic [gb3_pkg::POS_W-1:0]  out_row_ff, out_col_ff;
   logic                last_ff;
   logic                out_free;
   logic                single;
   logic                emit;
   logic                load;
   logic                sel_rb, sel_cb;
   logic [3:0]          clr;
   logic [3:0]          new_mask;
   gb3_pkg::sel_type    rs, cs;
   logic [RW-1:0]       row_pos;
   logic [CW-1:0]       col_pos;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign single   = (mask_ff != 4'd0) && ((mask_ff & (mask_ff - 4'd1)) == 4'd0);
   assign emit     = (mask_ff != 4'd0) && out_free;
   assign in_ready = (mask_ff == 4'd0) || (out_free && single);
   assign load     = in_valid && in_ready;

   assign new_mask = {in_flags.row_ge1  && in_flags.col_ge1,
                      in_flags.row_ge1  && in_flags.col_last,
                      in_flags.row_last && in_flags.col_ge1,
                      in_flags.row_last && in_flags.col_last};

   always_comb begin
      priority if (mask_ff[3]) begin
         sel_rb = 1'b0;
         sel_cb = 1'b0;
         clr    = 4'b1000;
      end else if (mask_ff[2]) begin
         sel_rb = 1'b0;
         sel_cb = 1'b1;
         clr    = 4'b0100;
      end else if (mask_ff[1]) begin
         sel_rb = 1'b1;
         sel_cb = 1'b0;
         clr    = 4'b0010;
      end else begin
         sel_rb = 1'b1;
         sel_cb = 1'b1;
         clr    = 4'b0001;
      end
   end

   assign rs      = gb3_pkg::border_sel(sel_rb, flags_ff.row_eq1, !flags_ff.row_ge1);
   assign cs      = gb3_pkg::border_sel(sel_cb, flags_ff.col_eq1, !flags_ff.col_ge1);
   assign row_pos = sel_rb ? row_ff : row_ff - RW'(1);
   assign col_pos = sel_cb ? col_ff : col_ff - CW'(1);

   always_comb begin
      mask_in = mask_ff;
      win_in  = win_ff;
      if (load) begin
         mask_in = new_mask;
         win_in  = {in_pix, in_mid, in_top, win_ff[8:3]};
      end else if (emit) begin
         mask_in = mask_ff & ~clr;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      if (load) begin
         flags_ff <= in_flags;
         row_ff   <= in_row;
         col_ff   <= in_col;
      end
      if (emit) begin
         red_ff     <= gb3_pkg::blur_chan(win_ff, rs, cs, gb3_pkg::CH_RED);
         green_ff   <= gb3_pkg::blur_chan(win_ff, rs, cs, gb3_pkg::CH_GREEN);
         blue_ff    <= gb3_pkg::blur_chan(win_ff, rs, cs, gb3_pkg::CH_BLUE);
         out_row_ff <= gb3_pkg::POS_W'(row_pos);
         out_col_ff <= gb3_pkg::POS_W'(col_pos);
         last_ff    <= single;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_out   = red_ff;
   assign rsp_green_out = green_ff;
   assign rsp_blue_out  = blue_ff;
   assign rsp_out_row   = out_row_ff;
   assign rsp_out_col   = out_col_ff;
   assign rsp_run_last  = last_ff;

   `GB3_ASSERT_NEXT(a_stall_holds_results, (mask_ff != 4'd0) && !out_free, $stable(mask_ff))
   `GB3_ASSERT_NEXT(a_window_shifts, load, win_ff[5:0] === $past(win_ff[8:3]))
   `GB3_ASSERT_IMP(a_no_result_dropped, load && (mask_ff != 4'd0), out_free && single)

endmodule

FILE: test/gaussian_blur_3x3_rgb_tb.sv
// Self-checking testbench for the streaming 3x3 Gaussian blur of RGB pixels.
module gaussian_blur_3x3_rgb_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import gb3_pkg::*;

   localparam int HOLD_CYCLES   = 80;
   localparam int RANDOM_PIXELS = 230;
   localparam int PRINT_LIMIT   = 40;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [POS_W-1:0]  row;
      logic [POS_W-1:0]  col;
      logic              last;
   } blurred_pixel_type;

   typedef logic [2:0][1:0] taps_type;

   typedef enum int {
      ALWAYS_READY,
      RANDOM_STALL,
      EVERY_FOURTH,
      MOSTLY_STALLED
   } ready_mode_type;

   logic                clock;
   logic                reset        = 1'b1;
   logic                req_valid    = 1'b0;
   logic                req_ready;
   logic [CHAN_W-1:0]   req_red_in   = '0;
   logic [CHAN_W-1:0]   req_green_in = '0;
   logic [CHAN_W-1:0]   req_blue_in  = '0;
   logic                rsp_valid;
   logic                rsp_ready    = 1'b0;
   logic [CHAN_W-1:0]   rsp_red_out;
   logic [CHAN_W-1:0]   rsp_green_out;
   logic [CHAN_W-1:0]   rsp_blue_out;
   logic [POS_W-1:0]    rsp_out_row;
   logic [POS_W-1:0]    rsp_out_col;
   logic                rsp_run_last;
   logic                csr_valid    = 1'b0;
   logic                csr_ready;
   logic [0:0]          csr_index    = '0;
   logic [SIZE_W-1:0]   csr_data     = '0;

   // Mirror of the block's state, kept in step with every accepted beat.
   logic [PIX_W-1:0]    upper_px  [MAX_COLS_DEF];
   logic [PIX_W-1:0]    middle_px [MAX_COLS_DEF];
   logic [PIX_W-1:0]    window_px [9];
   logic [POS_W-1:0]    next_row  = '0;
   logic [POS_W-1:0]    next_col  = '0;
   logic [SIZE_W-1:0]   rows_reg  = SIZE_W'(1);
   logic [SIZE_W-1:0]   cols_reg  = SIZE_W'(1);

   blurred_pixel_type   blurred_due [$];
   int                  mismatch_count = 0;
   int                  burst_left     = 0;
   bit                  steady_sender  = 1'b0;
   bit                  hold_request   = 1'b0;

   gaussian_blur_3x3_rgb dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_red_in    (req_red_in),
      .req_green_in  (req_green_in),
      .req_blue_in   (req_blue_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_run_last  (rsp_run_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #3ms;
      $display("== FAIL ==");
      $finish;
   end

   function automatic int size_in_use(logic [SIZE_W-1:0] value, int limit);
      if (value == 0) return 1;
      if (value > limit) return limit;
      return value;
   endfunction

   function automatic logic [CHAN_W-1:0] blur_channel(taps_type rt, taps_type ct, int lsb);
      int               sum;
      int               weight;
      logic [PIX_W-1:0] p;
      sum = 0;
      for (int a = 0; a < 3; a++) begin
         for (int b = 0; b < 3; b++) begin
            weight = ((a == 1) ? 2 : 1) * ((b == 1) ? 2 : 1);
            p      = window_px[ct[b] * 3 + rt[a]];
            sum    = sum + weight * p[lsb +: CHAN_W];
         end
      end
      return CHAN_W'(sum >> 4);
   endfunction

   function automatic void predict_blur(logic [PIX_W-1:0] px);
      int                rows_used;
      int                cols_used;
      int                r;
      int                c;
      int                nr;
      int                nc;
      logic [PIX_W-1:0]  top;
      logic [PIX_W-1:0]  mid;
      taps_type          row_taps [2];
      taps_type          col_taps [2];
      int                row_at [2];
      int                col_at [2];
      blurred_pixel_type res;
      rows_used = size_in_use(rows_reg, MAX_ROWS_DEF);
      cols_used = size_in_use(cols_reg, MAX_COLS_DEF);
      r = next_row;
      c = next_col;
      if (r > rows_used - 1) r = rows_used - 1;
      if (c > cols_used - 1) c = cols_used - 1;
      top          = upper_px[c];
      mid          = middle_px[c];
      upper_px[c]  = mid;
      middle_px[c] = px;
      for (int k = 0; k < 6; k++) window_px[k] = window_px[k + 3];
      window_px[6] = top;
      window_px[7] = mid;
      window_px[8] = px;
      nr = 0;
      nc = 0;
      if (r >= 1) begin
         row_taps[nr] = {2'd2, 2'd1, (r == 1) ? 2'd1 : 2'd0};
         row_at[nr]   = r - 1;
         nr++;
      end
      if (r == rows_used - 1) begin
         row_taps[nr] = {2'd2, 2'd2, (r == 0) ? 2'd2 : 2'd1};
         row_at[nr]   = r;
         nr++;
      end
      if (c >= 1) begin
         col_taps[nc] = {2'd2, 2'd1, (c == 1) ? 2'd1 : 2'd0};
         col_at[nc]   = c - 1;
         nc++;
      end
      if (c == cols_used - 1) begin
         col_taps[nc] = {2'd2, 2'd2, (c == 0) ? 2'd2 : 2'd1};
         col_at[nc]   = c;
         nc++;
      end
      for (int a = 0; a < nr; a++) begin
         for (int b = 0; b < nc; b++) begin
            res.red   = blur_channel(row_taps[a], col_taps[b], CH_RED * CHAN_W);
            res.green = blur_channel(row_taps[a], col_taps[b], CH_GREEN * CHAN_W);
            res.blue  = blur_channel(row_taps[a], col_taps[b], CH_BLUE * CHAN_W);
            res.row   = POS_W'(row_at[a]);
            res.col   = POS_W'(col_at[b]);
            res.last  = (a == nr - 1) && (b == nc - 1);
            blurred_due.push_back(res);
         end
      end
      if (c >= cols_used - 1) begin
         c = 0;
         r = (r >= rows_used - 1) ? 0 : r + 1;
      end else begin
         c++;
      end
      next_row = POS_W'(r);
      next_col = POS_W'(c);
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatch_count < PRINT_LIMIT) $display("MISMATCH at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [POS_W-1:0] got,
                              input logic [POS_W-1:0] want, input blurred_pixel_type exp);
      if (got !== want) begin
         report_mismatch($sformatf("%s of row %0d col %0d: got %0d, expected %0d",
                                   name, exp.row, exp.col, got, want));
      end
   endtask

   always @(posedge clock) begin : compare_results
      blurred_pixel_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (blurred_due.size() == 0) begin
            report_mismatch($sformatf("beat for row %0d col %0d with none expected",
                                      rsp_out_row, rsp_out_col));
         end else begin
            want = blurred_due.pop_front();
            check_field("red", POS_W'(rsp_red_out), POS_W'(want.red), want);
            check_field("green", POS_W'(rsp_green_out), POS_W'(want.green), want);
            check_field("blue", POS_W'(rsp_blue_out), POS_W'(want.blue), want);
            check_field("row", rsp_out_row, want.row, want);
            check_field("col", rsp_out_col, want.col, want);
            check_field("run_last", POS_W'(rsp_run_last), POS_W'(want.last), want);
         end
      end
   end

   // The receiver changes its stall pattern now and then, and holds off on request.
   initial begin : receiver_pattern
      ready_mode_type mode;
      int             mode_left;
      mode      = ALWAYS_READY;
      mode_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if (mode_left == 0) begin
               mode      = ready_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(10, 80);
            end
            mode_left--;
            case (mode)
               ALWAYS_READY: begin
                  rsp_ready <= 1'b1;
               end
               RANDOM_STALL: begin
                  rsp_ready <= ($urandom_range(0, 2) != 0);
               end
               EVERY_FOURTH: begin
                  rsp_ready <= (mode_left % 4 == 0);
               end
               default: begin
                  rsp_ready <= ($urandom_range(0, 7) == 0);
               end
            endcase
         end
      end
   end

   function automatic logic [CHAN_W-1:0] random_channel();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return CHAN_W'($urandom);
      endcase
   endfunction

   task automatic send_pixel(input logic [CHAN_W-1:0] red, input logic [CHAN_W-1:0] green,
                             input logic [CHAN_W-1:0] blue);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = (steady_sender || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid    <= 1'b1;
      req_red_in   <= red;
      req_green_in <= green;
      req_blue_in  <= blue;
      do @(posedge clock); while (!req_ready);
      predict_blur({red, green, blue});
   endtask

   task automatic send_random_pixels(input int count);
      for (int i = 0; i < count; i++) send_pixel(random_channel(), random_channel(),
                                                 random_channel());
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (blurred_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_size(input csr_index_type which, input int value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= which;
      csr_data  <= SIZE_W'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (which == CSR_IMAGE_ROWS) rows_reg = SIZE_W'(value);
      else cols_reg = SIZE_W'(value);
   endtask

   task automatic set_size(input int rows, input int cols);
      write_size(CSR_IMAGE_ROWS, rows);
      write_size(CSR_IMAGE_COLS, cols);
   endtask

   task automatic send_image(input int rows, input int cols);
      set_size(rows, cols);
      send_random_pixels(size_in_use(SIZE_W'(rows), MAX_ROWS_DEF)
                         * size_in_use(SIZE_W'(cols), MAX_COLS_DEF));
   endtask

   // With the reset size of one by one, every pixel comes back unchanged.
   task automatic test_single_pixels();
      send_pixel(8'h00, 8'h00, 8'h00);
      send_pixel(8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'hAA, 8'h55, 8'h0F);
      send_pixel(8'h55, 8'hAA, 8'hF0);
      wait_drained();
   endtask

   task automatic test_small_images();
      set_size(3, 3);
      for (int i = 0; i < 9; i++) begin
         send_pixel((i % 2 == 1) ? 8'hFF : 8'h00, (i % 3 == 0) ? 8'hFF : 8'h00,
                    random_channel());
      end
      send_image(1, 3);
      send_image(3, 1);
      send_image(2, 2);
   endtask

   // Size registers of zero and above the limit, and a row cut short mid-line.
   task automatic test_size_saturation();
      write_size(CSR_IMAGE_ROWS, 0);
      write_size(CSR_IMAGE_COLS, 2047);
      send_random_pixels(6);
      write_size(CSR_IMAGE_COLS, MAX_COLS_DEF);
      send_random_pixels(3);
      write_size(CSR_IMAGE_COLS, 4);
      send_random_pixels(5);
      write_size(CSR_IMAGE_COLS, 0);
      send_random_pixels(2);
   endtask

   // The row count shrinks below the current row, which then acts as the last row.
   task automatic test_row_shrink();
      set_size(2047, 2);
      send_random_pixels(6);
      write_size(CSR_IMAGE_ROWS, 2);
      send_random_pixels(2);
   endtask

   // The width grows mid-image, so the last row reads stored rows of an earlier image.
   task automatic test_column_growth();
      send_image(3, 4);
      write_size(CSR_IMAGE_COLS, 2);
      send_random_pixels(4);
      write_size(CSR_IMAGE_COLS, 4);
      send_random_pixels(4);
   endtask

   task automatic test_full_input_stall();
      set_size(2, 8);
      steady_sender = 1'b1;
      hold_request  = 1'b1;
      send_random_pixels(32);
      steady_sender = 1'b0;
   endtask

   task automatic test_random_images();
      int sent;
      int rows;
      int cols;
      sent = 0;
      while (sent < RANDOM_PIXELS) begin
         case ($urandom_range(0, 7))
            0: begin
               rows = 1;
               cols = $urandom_range(1, 48);
            end
            1: begin
               rows = $urandom_range(1, 48);
               cols = 1;
            end
            2: begin
               rows = $urandom_range(1, 3);
               cols = $urandom_range(1, 3);
            end
            default: begin
               rows = $urandom_range(1, 6);
               cols = $urandom_range(1, 10);
            end
         endcase
         sent = sent + rows * cols;
         if (rows == 1 && $urandom_range(0, 1) == 1) rows = 0;
         if (cols == 1 && $urandom_range(0, 1) == 1) cols = 0;
         send_image(rows, cols);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_single_pixels();
      test_small_images();
      test_size_saturation();
      test_row_shrink();
      test_column_growth();
      test_full_input_stall();
      test_random_images();
      wait_drained();
      repeat (12) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/gb3_pkg.sv
rtl/gb3_line_buf.sv
rtl/gb3_blur_out.sv
rtl/gaussian_blur_3x3_rgb.sv
test/gaussian_blur_3x3_rgb_tb.sv
